[rtl/core/nepsel_pkg.sv]
`default_nettype none

package nepsel_pkg;

    // Field widths fixed by the channel formats.
    localparam int DIST_BITS = 36;
    localparam int RANK_BITS = 3;
    localparam int INDEX_OUT_BITS = 8;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic signed [15:0] query_x;
        logic signed [15:0] query_y;
        logic signed [15:0] query_z;
        logic signed [15:0] cand_x;
        logic signed [15:0] cand_y;
        logic signed [15:0] cand_z;
        logic [7:0]         cand_index;
        logic               first_cand;
        logic               last_cand;
    } in_item_t;

    typedef struct packed {
        logic [RANK_BITS-1:0]      rank;
        logic                      entry_valid;
        logic [INDEX_OUT_BITS-1:0] entry_index;
        logic [DIST_BITS-1:0]      entry_dist_sq;
        logic                      last_result;
    } out_item_t;

    // Run control that travels with an item down the pipeline.
    typedef struct packed {
        logic first;
        logic last;
    } item_flags_t;

endpackage

`default_nettype wire

[rtl/core/nepsel_dist.sv]
`default_nettype none

module nepsel_dist #(
    parameter int COORD_BITS      = 16,
    parameter int CAND_INDEX_BITS = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire nepsel_pkg::in_item_t        s_data,
    output logic                             sq_valid,
    input  wire logic                        sq_ready,
    output logic [2*COORD_BITS-1:0]          sq_x,
    output logic [2*COORD_BITS-1:0]          sq_y,
    output logic [2*COORD_BITS-1:0]          sq_z,
    output logic [CAND_INDEX_BITS-1:0]       sq_index,
    output nepsel_pkg::item_flags_t          sq_flags
);

    localparam int SQ_W = 2 * COORD_BITS;

    nepsel_pkg::in_item_t           in_reg;
    logic                           in_valid_reg;
    logic [SQ_W-1:0]                sqx_reg, sqy_reg, sqz_reg;
    logic [CAND_INDEX_BITS-1:0]     index_reg;
    nepsel_pkg::item_flags_t        flags_reg;
    logic                           sq_valid_reg;
    logic                           load_sq;
    logic [SQ_W-1:0]                sqx_next, sqy_next, sqz_next;

    // Squared difference of two coordinates taken from their low COORD_BITS bits.
    function automatic logic [SQ_W-1:0] diff_sq(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        logic signed [COORD_BITS-1:0] as;
        logic signed [COORD_BITS-1:0] bs;
        logic signed [COORD_BITS:0]   d;
        logic [COORD_BITS-1:0]        m;
        as = COORD_BITS'($unsigned(a));
        bs = COORD_BITS'($unsigned(b));
        d  = (COORD_BITS + 1)'(as) - (COORD_BITS + 1)'(bs);
        m  = d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
        return SQ_W'(m) * SQ_W'(m);
    endfunction

    always_comb begin
        sqx_next = diff_sq(in_reg.query_x, in_reg.cand_x);
        sqy_next = diff_sq(in_reg.query_y, in_reg.cand_y);
        sqz_next = diff_sq(in_reg.query_z, in_reg.cand_z);
    end

    assign load_sq = in_valid_reg && (!sq_valid_reg || sq_ready);
    assign s_ready = !in_valid_reg || load_sq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (!sq_valid_reg || sq_ready) begin
                sq_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (load_sq) begin
            sqx_reg         <= sqx_next;
            sqy_reg         <= sqy_next;
            sqz_reg         <= sqz_next;
            index_reg       <= CAND_INDEX_BITS'(in_reg.cand_index);
            flags_reg.first <= in_reg.first_cand;
            flags_reg.last  <= in_reg.last_cand;
        end
    end

    assign sq_valid = sq_valid_reg;
    assign sq_x     = sqx_reg;
    assign sq_y     = sqy_reg;
    assign sq_z     = sqz_reg;
    assign sq_index = index_reg;
    assign sq_flags = flags_reg;

endmodule

`default_nettype wire

[rtl/core/nepsel_list.sv]
`default_nettype none

module nepsel_list #(
    parameter int NEAREST_COUNT   = 8,
    parameter int CAND_INDEX_BITS = 8,
    parameter int COORD_BITS      = 16
) (
    input  wire logic                                            aclk,
    input  wire logic                                            aresetn,
    input  wire logic                                            sq_valid,
    output logic                                                 sq_ready,
    input  wire logic [2*COORD_BITS-1:0]                         sq_x,
    input  wire logic [2*COORD_BITS-1:0]                         sq_y,
    input  wire logic [2*COORD_BITS-1:0]                         sq_z,
    input  wire logic [CAND_INDEX_BITS-1:0]                      sq_index,
    input  wire nepsel_pkg::item_flags_t                         sq_flags,
    input  wire logic                                            emit_free,
    output logic                                                 emit_load,
    output logic [NEAREST_COUNT-1:0][nepsel_pkg::DIST_BITS-1:0]  list_dist,
    output logic [NEAREST_COUNT-1:0][CAND_INDEX_BITS-1:0]        list_index,
    output logic [NEAREST_COUNT-1:0]                             list_valid
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 2;
    localparam int DW    = nepsel_pkg::DIST_BITS;

    logic [NEAREST_COUNT-1:0][DW-1:0]              dist_reg, dist_cur, dist_next;
    logic [NEAREST_COUNT-1:0][CAND_INDEX_BITS-1:0] index_reg, index_cur, index_next;
    logic [NEAREST_COUNT-1:0]                      valid_reg, valid_cur, valid_next;
    logic [NEAREST_COUNT-1:0]                      closer;
    logic [SUM_W-1:0]                              sum;
    logic [DW-1:0]                                 cand_dist;
    logic                                          step;

    assign sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

    generate
        if (SUM_W > DW) begin : g_sat
            assign cand_dist = (|sum[SUM_W-1:DW]) ? nepsel_pkg::DIST_MAX : DW'(sum);
        end else begin : g_nosat
            assign cand_dist = DW'(sum);
        end
    endgenerate

    // A run marked first starts from an empty list.
    always_comb begin
        if (sq_flags.first) begin
            dist_cur  = {NEAREST_COUNT{nepsel_pkg::DIST_MAX}};
            index_cur = '0;
            valid_cur = '0;
        end else begin
            dist_cur  = dist_reg;
            index_cur = index_reg;
            valid_cur = valid_reg;
        end
    end

    // The list stays sorted with empty slots at the tail, so the slots that the
    // candidate beats form a contiguous tail; the first of them takes the candidate
    // and the rest take their upper neighbor.
    genvar k;
    generate
        for (k = 0; k < NEAREST_COUNT; k++) begin : g_slot
            assign closer[k] = !valid_cur[k] || (cand_dist < dist_cur[k]);
            if (k == 0) begin : g_head
                always_comb begin
                    if (closer[k]) begin
                        dist_next[k]  = cand_dist;
                        index_next[k] = sq_index;
                        valid_next[k] = 1'b1;
                    end else begin
                        dist_next[k]  = dist_cur[k];
                        index_next[k] = index_cur[k];
                        valid_next[k] = valid_cur[k];
                    end
                end
            end else begin : g_body
                always_comb begin
                    if (!closer[k]) begin
                        dist_next[k]  = dist_cur[k];
                        index_next[k] = index_cur[k];
                        valid_next[k] = valid_cur[k];
                    end else if (!closer[k-1]) begin
                        dist_next[k]  = cand_dist;
                        index_next[k] = sq_index;
                        valid_next[k] = 1'b1;
                    end else begin
                        dist_next[k]  = dist_cur[k-1];
                        index_next[k] = index_cur[k-1];
                        valid_next[k] = valid_cur[k-1];
                    end
                end
            end
        end
    endgenerate

    // A last item waits here until the output buffer can take the list.
    assign sq_ready  = !sq_flags.last || emit_free;
    assign step      = sq_valid && sq_ready;
    assign emit_load = step && sq_flags.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg  <= {NEAREST_COUNT{nepsel_pkg::DIST_MAX}};
            index_reg <= '0;
            valid_reg <= '0;
        end else if (step) begin
            dist_reg  <= dist_next;
            index_reg <= index_next;
            valid_reg <= valid_next;
        end
    end

    assign list_dist  = dist_next;
    assign list_index = index_next;
    assign list_valid = valid_next;

endmodule

`default_nettype wire

[rtl/core/nepsel_emit.sv]
`default_nettype none

module nepsel_emit #(
    parameter int NEAREST_COUNT   = 8,
    parameter int CAND_INDEX_BITS = 8
) (
    input  wire logic                                            aclk,
    input  wire logic                                            aresetn,
    input  wire logic                                            emit_load,
    input  wire logic [NEAREST_COUNT-1:0][nepsel_pkg::DIST_BITS-1:0] list_dist,
    input  wire logic [NEAREST_COUNT-1:0][CAND_INDEX_BITS-1:0]   list_index,
    input  wire logic [NEAREST_COUNT-1:0]                        list_valid,
    output logic                                                 emit_free,
    output logic                                                 m_valid,
    input  wire logic                                            m_ready,
    output nepsel_pkg::out_item_t                                m_data
);

    localparam int CNT_W = (NEAREST_COUNT > 1) ? $clog2(NEAREST_COUNT) : 1;
    localparam int DW    = nepsel_pkg::DIST_BITS;

    logic [NEAREST_COUNT-1:0][DW-1:0]              dist_reg;
    logic [NEAREST_COUNT-1:0][CAND_INDEX_BITS-1:0] index_reg;
    logic [NEAREST_COUNT-1:0]                      valid_reg;
    logic [CNT_W-1:0]                              cnt_reg;
    logic                                          busy_reg;
    logic                                          last_beat;

    assign last_beat = (cnt_reg == CNT_W'(NEAREST_COUNT - 1));
    assign emit_free = !busy_reg || (m_ready && last_beat);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (emit_load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (last_beat) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The snapshot shifts toward slot 0, which always holds the item on the port.
    always_ff @(posedge aclk) begin
        if (emit_load) begin
            dist_reg  <= list_dist;
            index_reg <= list_index;
            valid_reg <= list_valid;
        end else if (busy_reg && m_ready) begin
            for (int k = 0; k < NEAREST_COUNT - 1; k++) begin
                dist_reg[k]  <= dist_reg[k+1];
                index_reg[k] <= index_reg[k+1];
                valid_reg[k] <= valid_reg[k+1];
            end
        end
    end

    always_comb begin
        m_data.rank          = nepsel_pkg::RANK_BITS'(cnt_reg);
        m_data.entry_valid   = valid_reg[0];
        m_data.entry_index   = valid_reg[0] ?
                               nepsel_pkg::INDEX_OUT_BITS'(index_reg[0]) : '0;
        m_data.entry_dist_sq = valid_reg[0] ? dist_reg[0] : nepsel_pkg::DIST_MAX;
        m_data.last_result   = last_beat;
    end

    assign m_valid = busy_reg;

endmodule

`default_nettype wire

[rtl/core/nearest_eight_point_selector_core.sv]
// Nearest-point selector.
// The s_ channel carries one item per candidate: a query point, a candidate
// point and its index, plus first_cand and last_cand flags. The block forms the
// squared distance and inserts the candidate into a sorted list of the
// NEAREST_COUNT closest candidates; ties keep the earlier candidate ahead.
// first_cand empties the list before the insert. After an item with last_cand,
// the m_ channel delivers NEAREST_COUNT items in rank order, rank 0 closest,
// last_result set on the final one; empty ranks show entry_valid low.
// Throughput is one item per cycle unless a last item is held: input register,
// squaring stage, then the list update. A last item's first result reaches the
// m_ channel through the input register, the squaring stage and the output
// buffer, and the results then drain one by one as m_ready takes them. The list is
// copied into an output buffer, so later candidates keep flowing while results
// drain; a further last item waits until the buffer has delivered its final rank.
// A stall on m_ready back-pressures s_ready only once such a last item
// is held. Reset (synchronous, aresetn low) empties the list and drops any
// items in flight or undelivered results.
`default_nettype none

module nearest_eight_point_selector_core #(
    parameter int NEAREST_COUNT   = 8,
    parameter int CAND_INDEX_BITS = 8,
    parameter int COORD_BITS      = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire nepsel_pkg::in_item_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output nepsel_pkg::out_item_t      m_data
);

    localparam int SQ_W = 2 * COORD_BITS;

    logic                                                 sq_valid;
    logic                                                 sq_ready;
    logic [SQ_W-1:0]                                      sq_x, sq_y, sq_z;
    logic [CAND_INDEX_BITS-1:0]                           sq_index;
    nepsel_pkg::item_flags_t                              sq_flags;
    logic                                                 emit_free;
    logic                                                 emit_load;
    logic [NEAREST_COUNT-1:0][nepsel_pkg::DIST_BITS-1:0]  list_dist;
    logic [NEAREST_COUNT-1:0][CAND_INDEX_BITS-1:0]        list_index;
    logic [NEAREST_COUNT-1:0]                             list_valid;

    nepsel_dist #(
        .COORD_BITS      (COORD_BITS),
        .CAND_INDEX_BITS (CAND_INDEX_BITS)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .sq_valid (sq_valid),
        .sq_ready (sq_ready),
        .sq_x     (sq_x),
        .sq_y     (sq_y),
        .sq_z     (sq_z),
        .sq_index (sq_index),
        .sq_flags (sq_flags)
    );

    nepsel_list #(
        .NEAREST_COUNT   (NEAREST_COUNT),
        .CAND_INDEX_BITS (CAND_INDEX_BITS),
        .COORD_BITS      (COORD_BITS)
    ) u_list (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sq_valid   (sq_valid),
        .sq_ready   (sq_ready),
        .sq_x       (sq_x),
        .sq_y       (sq_y),
        .sq_z       (sq_z),
        .sq_index   (sq_index),
        .sq_flags   (sq_flags),
        .emit_free  (emit_free),
        .emit_load  (emit_load),
        .list_dist  (list_dist),
        .list_index (list_index),
        .list_valid (list_valid)
    );

    nepsel_emit #(
        .NEAREST_COUNT   (NEAREST_COUNT),
        .CAND_INDEX_BITS (CAND_INDEX_BITS)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .emit_load  (emit_load),
        .list_dist  (list_dist),
        .list_index (list_index),
        .list_valid (list_valid),
        .emit_free  (emit_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

[rtl/core/nepsel_checker.sv]
`default_nettype none

module nepsel_checker #(
    parameter int NEAREST_COUNT = 8
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire nepsel_pkg::out_item_t m_data
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // Ranks of one run follow each other without a gap.
    a_rank_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_result |=>
            m_valid && (m_data.rank == $past(m_data.rank) + 3'd1))
        else $error("rank sequence broken");

    // The final result sits on the last rank.
    a_last_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_result |->
            m_data.rank == nepsel_pkg::RANK_BITS'(NEAREST_COUNT - 1))
        else $error("last_result on wrong rank");

    // Every run holds at least the candidate of its last item.
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.rank == 3'd0) |-> m_data.entry_valid)
        else $error("rank 0 empty");

    // Empty ranks report the fixed empty values.
    a_empty_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.entry_valid |->
            (m_data.entry_index == '0) && (m_data.entry_dist_sq == nepsel_pkg::DIST_MAX))
        else $error("empty rank carries data");

endmodule

bind nearest_eight_point_selector_core nepsel_checker #(
    .NEAREST_COUNT (NEAREST_COUNT)
) u_nepsel_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
